@@ hdl/dst_offset_from_rule_top_assert.svh @@
// assertion helpers for the dst offset block
`ifndef DST_OFFSET_FROM_RULE_TOP_ASSERT_SVH
`define DST_OFFSET_FROM_RULE_TOP_ASSERT_SVH

// checked only outside reset
`define DOFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked through reset too
`define DOFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/dofr_pkg.sv @@
package dofr_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BASE_OFFSET    = 3'd0;
  localparam logic [2:0] REG_DST_OFFSET     = 3'd1;
  localparam logic [2:0] REG_START_MONTH    = 3'd2;
  localparam logic [2:0] REG_START_WEEK_DAY = 3'd3;
  localparam logic [2:0] REG_START_TIME     = 3'd4;
  localparam logic [2:0] REG_END_MONTH      = 3'd5;
  localparam logic [2:0] REG_END_WEEK_DAY   = 3'd6;
  localparam logic [2:0] REG_END_TIME       = 3'd7;

  localparam int LAST_WEEK = 5;

  // one transition rule
  typedef struct packed {
    logic [3:0]         month;
    logic [5:0]         week_day;
    logic [16:0]        tod;
    logic signed [17:0] offset;
  } rule_cfg_t;

  // days from 1970-01-01 to jan 1 of year 1970+y, valid for y in -1..140
  function automatic logic signed [17:0] jan1_days(input logic signed [9:0] y);
    int yi;
    yi = int'(y);
    return 18'(yi * 365 + ((yi + 1) >>> 2) - ((yi >= 131) ? 1 : 0));
  endfunction

  // days before month m in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    case (m)
      4'd1:    return 9'd0;
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  // month length in a common year
  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd2:                     return 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  return 5'd30;
      default:                  return 5'd31;
    endcase
  endfunction

endpackage

@@ hdl/dofr_year.sv @@
module dofr_year (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] utc,
  output logic [7:0]  yoff
);
  import dofr_pkg::*;

  // 2^40/675 rounded up, utc>>7 over 675 gives whole days
  localparam logic [30:0] DAY_RECIP = 31'd1628906116;
  // 2^20/365.2425, first guess at the year
  localparam logic [11:0] YEAR_RECIP = 12'd2871;

  logic [55:0] day_prod_r;
  logic [15:0] days_r;
  logic [27:0] yr_prod_r;
  logic [7:0]  yoff_r;

  logic [15:0] days_nxt;
  logic [7:0]  est;
  logic [7:0]  yoff_nxt;
  logic signed [17:0] j_lo, j_hi, days_s;

  assign days_nxt = day_prod_r[55:40];
  assign est      = yr_prod_r[27:20];
  assign days_s   = $signed({2'b0, days_r});
  assign j_lo     = jan1_days($signed({2'b0, est}));
  assign j_hi     = jan1_days($signed({2'b0, est}) + 10'sd1);

  // guess is off by at most one year
  always_comb begin
    yoff_nxt = est;
    if (days_s < j_lo) begin
      yoff_nxt = est - 8'd1;
    end else if (days_s >= j_hi) begin
      yoff_nxt = est + 8'd1;
    end
  end

  // three stages: day count, year guess, year fix
  always_ff @(posedge clk) begin
    if (en) begin
      day_prod_r <= utc[31:7] * DAY_RECIP;
      days_r     <= days_nxt;
      yr_prod_r  <= days_nxt * YEAR_RECIP;
      yoff_r     <= yoff_nxt;
    end
  end

  assign yoff = yoff_r;

endmodule

@@ hdl/dofr_rule.sv @@
module dofr_rule (
  input  logic                      clk,
  input  logic                      en,
  input  logic [7:0]                yoff,
  input  dofr_pkg::rule_cfg_t       cfg,
  output logic signed [35:0]        instant
);
  import dofr_pkg::*;

  // 2^22/7 rounded up, for the weekday
  localparam logic [19:0] WEEK_RECIP = 20'd599187;

  logic signed [5:0]  mz;
  logic signed [9:0]  ya;
  logic [3:0]         mi;
  logic               leap;
  logic signed [17:0] d1_nxt;
  logic [4:0]         len_nxt;

  logic signed [17:0] d1_r, d1b_r, day_r;
  logic [4:0]         len_r, lenb_r;
  logic [36:0]        wprod_r;
  logic signed [35:0] instant_r;

  logic [11:0] wk_t;
  logic [3:0]  wk;
  logic [5:0]  wdy6;
  logic [2:0]  wdy;
  logic [16:0] dpos_a, dpos_b, rem;
  logic [14:0] q;
  logic [2:0]  wd1;
  logic signed [3:0] diff;
  logic [2:0]  delta, lm, back;
  logic [3:0]  s;
  logic signed [17:0] day_nxt;
  logic signed [35:0] secs;

  // week and weekday from the packed field
  assign wk_t = {6'b0, cfg.week_day} * 12'd37;
  assign wk   = wk_t[11:8];
  assign wdy6 = cfg.week_day - ({2'b0, wk} * 6'd7);
  assign wdy  = wdy6[2:0];

  // month and year of the rule, rolling out-of-range months
  always_comb begin
    mz = $signed({2'b0, cfg.month}) - 6'sd1;
    ya = $signed({2'b0, yoff});
    mi = 4'(mz + 6'sd1);
    if (mz < 0) begin
      ya = ya - 10'sd1;
      mi = 4'd12;
    end else if (mz >= 6'sd12) begin
      ya = ya + 10'sd1;
      mi = 4'(mz - 6'sd11);
    end
    leap    = (ya[1:0] == 2'd2) && (ya != 10'sd130);
    d1_nxt  = jan1_days(ya) + $signed({9'b0, cum_days(mi)})
            + $signed({17'b0, leap && (mi > 4'd2)});
    len_nxt = month_len(mi) + {4'b0, leap && (mi == 4'd2)};
  end

  // weekday of the first of the month
  assign dpos_a = 17'(d1_r + 18'sd375);
  assign dpos_b = 17'(d1b_r + 18'sd375);
  assign q      = wprod_r[36:22];
  assign rem    = dpos_b - 17'(q * 17'd7);
  assign wd1    = rem[2:0];

  // transition day
  always_comb begin
    diff  = $signed({1'b0, wdy}) - $signed({1'b0, wd1});
    delta = (diff < 0) ? 3'(diff + 4'sd7) : 3'(diff);
    case (lenb_r)
      5'd28:   lm = 3'd6;
      5'd29:   lm = 3'd0;
      5'd30:   lm = 3'd1;
      default: lm = 3'd2;
    endcase
    s = {1'b0, wd1} + {1'b0, lm};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    back = (s[2:0] >= wdy) ? (s[2:0] - wdy) : 3'(s[2:0] + 3'd7 - wdy);
    if (wk == 4'(LAST_WEEK)) begin
      day_nxt = d1b_r + $signed({13'b0, lenb_r}) - 18'sd1 - $signed({15'b0, back});
    end else begin
      day_nxt = d1b_r + $signed({15'b0, delta})
              + $signed({14'b0, wk}) * 18'sd7 - 18'sd7;
    end
  end

  assign secs = 36'(day_r) * 36'sd86400;

  // four stages: month start, weekday product, day, instant
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r      <= d1_nxt;
      len_r     <= len_nxt;
      wprod_r   <= dpos_a * WEEK_RECIP;
      d1b_r     <= d1_r;
      lenb_r    <= len_r;
      day_r     <= day_nxt;
      instant_r <= secs + $signed({19'b0, cfg.tod}) - 36'(cfg.offset);
    end
  end

  assign instant = instant_r;

endmodule

@@ hdl/dst_offset_from_rule_top.sv @@
// Local time offset from a POSIX style daylight rule pair. Each utc_seconds
// transfer yields one result: the daylight offset and dst_active=1 inside
// the DST window of that UTC year, else the base offset. The block is an
// eight stage pipeline that takes one timestamp per cycle; the whole pipe,
// input included, holds while the output is stalled. Configuration writes
// are taken every cycle and should be made while no timestamps are in
// flight.
module dst_offset_from_rule_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] utc_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [17:0] offset_seconds, [23:18] zero
  output logic        out_tuser,  // [0] dst_active
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import dofr_pkg::*;

  localparam int DEPTH = 8;

  logic signed [17:0] base_off_r, dst_off_r;
  logic [3:0]  st_month_r, en_month_r;
  logic [5:0]  st_wd_r, en_wd_r;
  logic [16:0] st_tod_r, en_tod_r;

  logic [DEPTH-1:0] vld_r;
  logic [31:0] utc_r [DEPTH-1];
  logic en;
  logic [7:0] yoff;
  rule_cfg_t st_cfg, en_cfg;
  logic signed [35:0] st_inst, en_inst, u;
  logic active;
  logic [17:0] off_r;
  logic act_r;

  assign en        = !vld_r[DEPTH-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_off_r <= '0;
      dst_off_r  <= '0;
      st_month_r <= 4'd3;
      st_wd_r    <= 6'd35;
      st_tod_r   <= 17'd3600;
      en_month_r <= 4'd10;
      en_wd_r    <= 6'd35;
      en_tod_r   <= 17'd3600;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_OFFSET:    base_off_r <= $signed(cfg_data);
        REG_DST_OFFSET:     dst_off_r  <= $signed(cfg_data);
        REG_START_MONTH:    st_month_r <= cfg_data[3:0];
        REG_START_WEEK_DAY: st_wd_r    <= cfg_data[5:0];
        REG_START_TIME:     st_tod_r   <= cfg_data[16:0];
        REG_END_MONTH:      en_month_r <= cfg_data[3:0];
        REG_END_WEEK_DAY:   en_wd_r    <= cfg_data[5:0];
        REG_END_TIME:       en_tod_r   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign st_cfg = '{month: st_month_r, week_day: st_wd_r, tod: st_tod_r, offset: base_off_r};
  assign en_cfg = '{month: en_month_r, week_day: en_wd_r, tod: en_tod_r, offset: dst_off_r};

  // valid bits beside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  // timestamp carried down to the compare
  always_ff @(posedge clk) begin
    if (en) begin
      utc_r[0] <= in_tdata;
      for (int i = 1; i < DEPTH - 1; i++) begin
        utc_r[i] <= utc_r[i-1];
      end
    end
  end

  dofr_year u_year (
    .clk  (clk),
    .en   (en),
    .utc  (in_tdata),
    .yoff (yoff)
  );

  dofr_rule u_start (
    .clk     (clk),
    .en      (en),
    .yoff    (yoff),
    .cfg     (st_cfg),
    .instant (st_inst)
  );

  dofr_rule u_end (
    .clk     (clk),
    .en      (en),
    .yoff    (yoff),
    .cfg     (en_cfg),
    .instant (en_inst)
  );

  // window test, wrapping when start is not before end
  assign u = $signed({4'b0, utc_r[DEPTH-2]});
  always_comb begin
    if (st_inst < en_inst) begin
      active = (u >= st_inst) && (u < en_inst);
    end else begin
      active = (u >= st_inst) || (u < en_inst);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      off_r <= active ? dst_off_r : base_off_r;
      act_r <= active;
    end
  end

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = {6'b0, off_r};
  assign out_tuser  = act_r;

endmodule

@@ hdl/dofr_checker.sv @@
`include "dst_offset_from_rule_top_assert.svh"

module dofr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result holds
  `DOFR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // input is taken whenever the output side is not stalled
  `DOFR_ASSERT(a_in_ready, !(out_tvalid && !out_tready) |-> in_tready, "input blocked without stall")

  // pad bits stay zero
  `DOFR_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[23:18] == 6'd0, "pad bits set")

  // reset empties the pipe
  `DOFR_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result after reset")

endmodule

bind dst_offset_from_rule_top dofr_checker u_dofr_checker (.*);

@@ sim/dst_offset_from_rule_top_tb.sv @@
`timescale 1ns / 1ps

module dst_offset_from_rule_top_tb;
  import dofr_pkg::*;

  // expected offset and flag of one timestamp
  typedef struct {
    logic [31:0]        utc;
    logic signed [17:0] offset;
    logic               dst;
  } local_offset_t;

  // predicts local offsets from the rule pair and checks results in order
  class offset_scoreboard;
    rule_cfg_t     start_rule;
    rule_cfg_t     end_rule;
    local_offset_t offsets_due[$];
    int            errors;

    function new();
      start_rule = '{month: 4'd3, week_day: 6'd35, tod: 17'd3600, offset: 18'sd0};
      end_rule   = '{month: 4'd10, week_day: 6'd35, tod: 17'd3600, offset: 18'sd0};
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] index, logic [17:0] data);
      case (index)
        REG_BASE_OFFSET:    start_rule.offset   = data;
        REG_DST_OFFSET:     end_rule.offset     = data;
        REG_START_MONTH:    start_rule.month    = data[3:0];
        REG_START_WEEK_DAY: start_rule.week_day = data[5:0];
        REG_START_TIME:     start_rule.tod      = data[16:0];
        REG_END_MONTH:      end_rule.month      = data[3:0];
        REG_END_WEEK_DAY:   end_rule.week_day   = data[5:0];
        REG_END_TIME:       end_rule.tod        = data[16:0];
        default: ;
      endcase
    endfunction

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b != 0) && ((a < 0) != (b < 0))) q--;
      return q;
    endfunction

    function longint fmod(longint a, longint b);
      return a - fdiv(a, b) * b;
    endfunction

    // days since 1970-01-01 of a civil date
    function longint date_days(longint y, longint m, longint d);
      longint yy, era, yoe, mp, doy;
      yy  = (m <= 2) ? y - 1 : y;
      era = fdiv(yy, 400);
      yoe = yy - era * 400;
      mp  = (m > 2) ? m - 3 : m + 9;
      doy = (153 * mp + 2) / 5 + d - 1;
      return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
    endfunction

    function longint civil_year(longint z);
      longint zz, era, doe, yoe, doy, mp, y;
      zz  = z + 719468;
      era = fdiv(zz, 146097);
      doe = zz - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      y   = yoe + era * 400;
      return (mp >= 10) ? y + 1 : y;
    endfunction

    function longint days_in_month(longint y, longint m);
      int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      bit leap;
      leap = (fmod(y, 4) == 0 && fmod(y, 100) != 0) || fmod(y, 400) == 0;
      if (m == 2 && leap) return 29;
      return lens[m - 1];
    endfunction

    // utc-referenced instant of a rule before its offset is taken off
    function longint rule_local(longint year, rule_cfg_t r);
      longint mz, y, m, week, wday, day;
      mz   = longint'(r.month) - 1;
      y    = year + fdiv(mz, 12);
      m    = fmod(mz, 12) + 1;
      week = r.week_day / 7;
      wday = r.week_day % 7;
      if (week == LAST_WEEK) begin
        day = date_days(y, m, days_in_month(y, m));
        day -= fmod(fmod(day + 4, 7) - wday, 7);
      end else begin
        day = date_days(y, m, 1);
        day += fmod(wday - fmod(day + 4, 7), 7);
        day += 7 * (week - 1);
      end
      return day * 86400 + longint'(r.tod);
    endfunction

    function longint start_instant(longint year);
      return rule_local(year, start_rule) - longint'(start_rule.offset);
    endfunction

    function longint end_instant(longint year);
      return rule_local(year, end_rule) - longint'(end_rule.offset);
    endfunction

    function void note_timestamp(logic [31:0] utc);
      longint t, year, st, en;
      local_offset_t e;
      t    = longint'(utc);
      year = civil_year(t / 86400);
      st   = start_instant(year);
      en   = end_instant(year);
      e.utc = utc;
      if (st < en) e.dst = (t >= st) && (t < en);
      else         e.dst = (t >= st) || (t < en);
      e.offset = e.dst ? end_rule.offset : start_rule.offset;
      offsets_due.push_back(e);
    endfunction

    function void check_result(logic signed [17:0] offset, logic dst);
      local_offset_t e;
      if (offsets_due.size() == 0) begin
        $error("result with no timestamp pending: offset_seconds %0d", offset);
        errors++;
        return;
      end
      e = offsets_due.pop_front();
      if (offset !== e.offset) begin
        $error("utc %0d offset_seconds expected %0d actual %0d", e.utc, e.offset, offset);
        errors++;
      end
      if (dst !== e.dst) begin
        $error("utc %0d dst_active expected %0d actual %0d", e.utc, e.dst, dst);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [31:0] utc_seconds
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [17:0] offset_seconds, [23:18] zero
  logic        out_tuser;   // [0] dst_active
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [17:0] cfg_data;

  offset_scoreboard tz_sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  dst_offset_from_rule_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side stalls
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // watch every timestamp and result transfer
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) tz_sb.note_timestamp(in_tdata);
    if (rst_n && out_tvalid && out_tready) tz_sb.check_result(out_tdata[17:0], out_tuser);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("dst_offset_from_rule_top test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] index, logic [17:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tz_sb.write_reg(index, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_timestamp(logic [31:0] utc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= utc;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // let the pipe empty before a register write
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tz_sb.offsets_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_rules(int base, int dst, int sm, int swd, int st,
                            int em, int ewd, int et);
    write_reg(REG_BASE_OFFSET, 18'(base));
    write_reg(REG_DST_OFFSET, 18'(dst));
    write_reg(REG_START_MONTH, 18'(sm));
    write_reg(REG_START_WEEK_DAY, 18'(swd));
    write_reg(REG_START_TIME, 18'(st));
    write_reg(REG_END_MONTH, 18'(em));
    write_reg(REG_END_WEEK_DAY, 18'(ewd));
    write_reg(REG_END_TIME, 18'(et));
  endtask

  function automatic int rand_offset();
    return int'($urandom_range(179998)) - 89999;
  endfunction

  // mostly near a transition of a random year, else anywhere
  function automatic logic [31:0] pick_utc();
    longint year, t;
    if ($urandom_range(99) < 35) return $urandom;
    year = $urandom_range(2105, 1970);
    t = $urandom_range(1) ? tz_sb.start_instant(year) : tz_sb.end_instant(year);
    t += longint'($urandom_range(8)) - 4;
    if ($urandom_range(3) == 0) t += longint'($urandom_range(200000)) - 100000;
    if (t < 0) t = 0;
    if (t > 64'hFFFFFFFF) t = 64'hFFFFFFFF;
    return t[31:0];
  endfunction

  task automatic random_burst(int n);
    repeat (n) send_timestamp(pick_utc());
  endtask

  initial begin
    longint st, en;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_BASE_OFFSET;
    cfg_data      = '0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset rules around the edges of 2024 and the extremes
    st = tz_sb.start_instant(2024);
    en = tz_sb.end_instant(2024);
    send_timestamp(32'd0);
    send_timestamp(32'hFFFFFFFF);
    send_timestamp(32'hAAAAAAAA);
    send_timestamp(32'h55555555);
    send_timestamp(32'(st - 1));
    send_timestamp(32'(st));
    send_timestamp(32'(en - 1));
    send_timestamp(32'(en));
    send_timestamp(32'd1704067199);
    send_timestamp(32'd1704067200);
    drain();

    // offsets and times at their extremes, months and weeks out of range
    load_rules(-89999, 89999, 0, 0, 0, 15, 63, 131071);
    st = tz_sb.start_instant(2000);
    en = tz_sb.end_instant(2000);
    send_timestamp(32'(st - 1));
    send_timestamp(32'(st));
    send_timestamp(32'(en - 1));
    send_timestamp(32'(en));
    send_timestamp(32'd946684800);
    drain();
    load_rules(89999, -89999, 15, 63, 131071, 0, 0, 0);
    st = tz_sb.start_instant(2030);
    en = tz_sb.end_instant(2030);
    send_timestamp(32'(st));
    send_timestamp(32'(en - 1));
    send_timestamp(32'(en));
    drain();

    // start equal to end keeps daylight time on all year
    load_rules(3600, 3600, 4, 8, 7200, 4, 8, 7200);
    send_timestamp(32'd0);
    send_timestamp(32'hFFFFFFFF);
    send_timestamp(32'd1000000000);
    drain();

    // random phases with the idling mix moving through three settings
    for (int phase = 0; phase < 6; phase++) begin
      send_idle_pct = (phase < 2) ? 31 : (phase < 4) ? 64 : 0;
      recv_idle_pct = (phase < 2) ? 64 : (phase < 4) ? 31 : 0;
      if (phase == 0)
        load_rules(3600, 7200, 3, 35, 7200, 10, 35, 10800);
      else if (phase == 3)
        load_rules(36000, 39600, 10, 7, 7200, 4, 7, 10800);
      else
        load_rules(rand_offset(), rand_offset(), $urandom_range(15), $urandom_range(63),
                   $urandom_range(131071), $urandom_range(15), $urandom_range(63),
                   $urandom_range(131071));
      random_burst(120);
      drain();
    end

    if (tz_sb.errors == 0)
      $display("dst_offset_from_rule_top test passed");
    else
      $display("dst_offset_from_rule_top test failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/dofr_pkg.sv
hdl/dofr_year.sv
hdl/dofr_rule.sv
hdl/dst_offset_from_rule_top.sv
hdl/dofr_checker.sv
sim/dst_offset_from_rule_top_tb.sv
